// ----- sv/keyed_record_table_macros.svh -----
// Assertion macros for the keyed record table.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// same-cycle implication, held off during reset
`define KRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_record_table: check failed");

// next-cycle implication, held off during reset
`define KRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_record_table: check failed");

`endif

// ----- sv/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
// No dependencies; imported by the cell, the controller and the top level.
package krt_pkg;

	localparam int TABLE_DEPTH_DEF  = 64;
	localparam int ID_BITS_DEF      = 16;
	localparam int PAYLOAD_BITS_DEF = 64;
	localparam int CNT_W_DEF        = $clog2(TABLE_DEPTH_DEF + 1);

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_EDIT = 2'd1,
		KIND_DEL  = 2'd2,
		KIND_FIND = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EXHAUSTED = 2'd3
	} status_t;

	// what the walking token is doing as it passes a cell
	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_SHIFT  = 2'd1,
		MODE_HIT    = 2'd2
	} mode_t;

	typedef struct packed {
		logic  tok;
		mode_t mode;
	} carry_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

endpackage

// ----- sv/krt_cell.sv -----
// One table slot: stored identifier and payload, plus the token register
// handed to the next slot. Depends on krt_pkg.
module krt_cell #(
	parameter int IDX          = 0,
	parameter int ID_BITS      = krt_pkg::ID_BITS_DEF,
	parameter int PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_W        = krt_pkg::CNT_W_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  krt_pkg::carry_t         c_in,
	input  logic [PAYLOAD_BITS-1:0] cpay_in,
	output krt_pkg::carry_t         c_out,
	output logic [PAYLOAD_BITS-1:0] cpay_out,
	input  krt_pkg::kind_t          req_kind,
	input  logic [ID_BITS-1:0]      req_key,
	input  logic [PAYLOAD_BITS-1:0] req_pay,
	input  logic                    add_we,
	input  logic [ID_BITS-1:0]      add_id,
	input  logic [PAYLOAD_BITS-1:0] add_pay,
	input  logic [CNT_W-1:0]        count,
	input  logic [ID_BITS-1:0]      nb_id,
	input  logic [PAYLOAD_BITS-1:0] nb_pay,
	output logic [ID_BITS-1:0]      id_o,
	output logic [PAYLOAD_BITS-1:0] pay_o
);
	import krt_pkg::*;

	logic [ID_BITS-1:0]      id_q, id_d;
	logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
	carry_t                  c_q, c_d;
	logic [PAYLOAD_BITS-1:0] cpay_q, cpay_d;
	logic                    occupied;

	assign occupied = count > CNT_W'(IDX);

	always_comb begin
		c_d    = c_in;
		cpay_d = cpay_in;
		id_d   = id_q;
		pay_d  = pay_q;
		if (add_we && count == CNT_W'(IDX)) begin
			id_d  = add_id;
			pay_d = add_pay;
		end
		if (c_in.tok) begin
			case (c_in.mode)
				MODE_SEARCH: begin
					if (occupied && id_q == req_key) begin
						case (req_kind)
							KIND_EDIT: begin
								pay_d     = req_pay;
								c_d.mode  = MODE_HIT;
							end
							KIND_DEL: begin
								id_d      = nb_id;
								pay_d     = nb_pay;
								c_d.mode  = MODE_SHIFT;
							end
							KIND_FIND: begin
								cpay_d    = pay_q;
								c_d.mode  = MODE_HIT;
							end
							default: ;
						endcase
					end
				end
				// close the gap left by a delete, one slot per cycle
				MODE_SHIFT: begin
					id_d  = nb_id;
					pay_d = nb_pay;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '{tok: 1'b0, mode: MODE_SEARCH};
		end else begin
			c_q <= c_d;
		end
	end

	always_ff @(posedge clk) begin
		cpay_q <= cpay_d;
		id_q   <= id_d;
		pay_q  <= pay_d;
	end

	assign c_out    = c_q;
	assign cpay_out = cpay_q;
	assign id_o     = id_q;
	assign pay_o    = pay_q;

endmodule

// ----- sv/krt_ctrl.sv -----
// Request controller: command handshake, add path, identifier counter,
// fill count and result registers. Depends on krt_pkg.
module krt_ctrl #(
	parameter int TABLE_DEPTH  = krt_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS      = krt_pkg::ID_BITS_DEF,
	parameter int PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_W        = krt_pkg::CNT_W_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic [ID_BITS-1:0]      key_id,
	input  logic [PAYLOAD_BITS-1:0] payload,
	input  krt_pkg::carry_t         tail_c,
	input  logic [PAYLOAD_BITS-1:0] tail_pay,
	output krt_pkg::carry_t         inj,
	output krt_pkg::kind_t          req_kind,
	output logic [ID_BITS-1:0]      req_key,
	output logic [PAYLOAD_BITS-1:0] req_pay,
	output logic                    add_we,
	output logic [ID_BITS-1:0]      add_id,
	output logic [CNT_W-1:0]        count,
	output logic                    done,
	output logic [1:0]              status,
	output logic [ID_BITS-1:0]      result_id,
	output logic [PAYLOAD_BITS-1:0] result_payload
);
	import krt_pkg::*;

	state_t                  state_q, state_d;
	carry_t                  inj_q;
	kind_t                   kind_in;
	kind_t                   kind_q;
	logic [ID_BITS-1:0]      key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0]        count_q;
	logic [ID_BITS:0]        next_id_q;
	logic                    done_q;
	status_t                 status_q;
	logic [ID_BITS-1:0]      rid_q;
	logic [PAYLOAD_BITS-1:0] rpay_q;
	logic                    accept;
	logic                    full;
	logic                    exhausted;

	assign kind_in   = kind_t'(kind);
	assign full      = count_q == CNT_W'(TABLE_DEPTH);
	assign exhausted = next_id_q[ID_BITS];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start && kind_in != KIND_ADD) state_d = ST_WALK;
			ST_WALK: if (tail_c.tok) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_WALK: busy = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;
	assign add_we = accept && kind_in == KIND_ADD && !full && !exhausted;
	assign add_id = next_id_q[ID_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			inj_q     <= '{tok: 1'b0, mode: MODE_SEARCH};
			count_q   <= '0;
			next_id_q <= (ID_BITS+1)'(1);
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			inj_q.tok <= accept && kind_in != KIND_ADD;
			inj_q.mode <= MODE_SEARCH;
			done_q    <= (accept && kind_in == KIND_ADD) || tail_c.tok;
			if (add_we) begin
				count_q   <= count_q + CNT_W'(1);
				next_id_q <= next_id_q + (ID_BITS+1)'(1);
			end else if (tail_c.tok && tail_c.mode != MODE_SEARCH && kind_q == KIND_DEL) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_in;
			key_q  <= key_id;
			pay_q  <= payload;
		end
		if (accept && kind_in == KIND_ADD) begin
			rpay_q <= '0;
			if (full) begin
				status_q <= STAT_FULL;
				rid_q    <= '0;
			end else if (exhausted) begin
				status_q <= STAT_EXHAUSTED;
				rid_q    <= '0;
			end else begin
				status_q <= STAT_OK;
				rid_q    <= next_id_q[ID_BITS-1:0];
			end
		end else if (tail_c.tok) begin
			if (tail_c.mode == MODE_SEARCH) begin
				status_q <= STAT_NOT_FOUND;
				rid_q    <= '0;
				rpay_q   <= '0;
			end else if (kind_q == KIND_FIND) begin
				status_q <= STAT_OK;
				rid_q    <= key_q;
				rpay_q   <= tail_pay;
			end else begin
				status_q <= STAT_OK;
				rid_q    <= '0;
				rpay_q   <= '0;
			end
		end
	end

	assign inj            = inj_q;
	assign req_kind       = kind_q;
	assign req_key        = key_q;
	assign req_pay        = pay_q;
	assign count          = count_q;
	assign done           = done_q;
	assign status         = status_q;
	assign result_id      = rid_q;
	assign result_payload = rpay_q;

endmodule

// ----- sv/keyed_record_table.sv -----
// Keyed record table: insertion-ordered records of identifier plus payload.
// Requests: add, edit, delete, find. A command is taken at a rising edge with
// start high and busy low; kind, key_id and payload are sampled there.
// Every command gives one result word, shown for exactly one cycle with done
// high, together with status, result_id, result_payload and entry_count.
// The receiver cannot stall; the result must be taken in that cycle.
// Add is handled by the controller alone: done follows in the cycle after the
// accept and busy stays low, so adds may issue every cycle.
// Edit, delete and find send a token down the row of TABLE_DEPTH slots, one
// slot per cycle; a delete shifts later slots down as the token passes.
// The token always runs the whole row, through the injection register and
// every slot's token register, then sets done; busy drops as done is shown,
// and the next command is taken at the edge ending that cycle.
// Reset empties the table (count zero) and sets the next identifier to one;
// slot contents are not cleared and no sweep is needed.
// Depends on krt_pkg, krt_ctrl, krt_cell and keyed_record_table_macros.svh.
`include "keyed_record_table_macros.svh"

module keyed_record_table #(
	parameter int TABLE_DEPTH  = krt_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS      = krt_pkg::ID_BITS_DEF,
	parameter int PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic [ID_BITS-1:0]      key_id,
	input  logic [PAYLOAD_BITS-1:0] payload,
	output logic                    done,
	output logic [1:0]              status,
	output logic [ID_BITS-1:0]      result_id,
	output logic [PAYLOAD_BITS-1:0] result_payload,
	output logic [CNT_W-1:0]        entry_count
);
	import krt_pkg::*;

	carry_t                  c_chain    [TABLE_DEPTH+1];
	logic [PAYLOAD_BITS-1:0] cpay_chain [TABLE_DEPTH+1];
	logic [ID_BITS-1:0]      ids        [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] pays       [TABLE_DEPTH];
	logic [ID_BITS-1:0]      nb_ids     [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] nb_pays    [TABLE_DEPTH];
	kind_t                   req_kind;
	logic [ID_BITS-1:0]      req_key;
	logic [PAYLOAD_BITS-1:0] req_pay;
	logic                    add_we;
	logic [ID_BITS-1:0]      add_id;
	logic [CNT_W-1:0]        count;

	krt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ID_BITS     (ID_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.key_id        (key_id),
		.payload       (payload),
		.tail_c        (c_chain[TABLE_DEPTH]),
		.tail_pay      (cpay_chain[TABLE_DEPTH]),
		.inj           (c_chain[0]),
		.req_kind      (req_kind),
		.req_key       (req_key),
		.req_pay       (req_pay),
		.add_we        (add_we),
		.add_id        (add_id),
		.count         (count),
		.done          (done),
		.status        (status),
		.result_id     (result_id),
		.result_payload(result_payload)
	);

	assign cpay_chain[0] = '0;
	assign entry_count   = count;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		// last slot has no upper neighbour; it keeps its own word
		if (i == TABLE_DEPTH - 1) begin : g_end
			assign nb_ids[i]  = ids[i];
			assign nb_pays[i] = pays[i];
		end else begin : g_mid
			assign nb_ids[i]  = ids[i+1];
			assign nb_pays[i] = pays[i+1];
		end

		krt_cell #(
			.IDX         (i),
			.ID_BITS     (ID_BITS),
			.PAYLOAD_BITS(PAYLOAD_BITS),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.c_in    (c_chain[i]),
			.cpay_in (cpay_chain[i]),
			.c_out   (c_chain[i+1]),
			.cpay_out(cpay_chain[i+1]),
			.req_kind(req_kind),
			.req_key (req_key),
			.req_pay (req_pay),
			.add_we  (add_we),
			.add_id  (add_id),
			.add_pay (payload),
			.count   (count),
			.nb_id   (nb_ids[i]),
			.nb_pay  (nb_pays[i]),
			.id_o    (ids[i]),
			.pay_o   (pays[i])
		);
	end

	`KRT_ASSERT_NXT(a_add_done, start && !busy && kind == KIND_ADD, done)
	`KRT_ASSERT_NXT(a_walk_busy, start && !busy && kind != KIND_ADD, busy)
	`KRT_ASSERT_IMP(a_tail_in_walk, c_chain[TABLE_DEPTH].tok, busy)
	`KRT_ASSERT_IMP(a_count_bound, done, entry_count <= CNT_W'(TABLE_DEPTH))

endmodule
